[design/bilateral_rgb_5x5_filter_assert.svh]
// Assertion macros for the 5x5 bilateral RGB filter.
`ifndef BILATERAL_RGB_5X5_FILTER_ASSERT_SVH
`define BILATERAL_RGB_5X5_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define BRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bilateral filter check failed");
`define BRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bilateral filter check failed");
`else
`define BRF_ASSERT_IMPL(lbl, ante, cons)
`define BRF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/brf_pkg.sv]
// Types, constants and tables of the 5x5 bilateral RGB filter.
`default_nettype none
package brf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_DIM_W = 11;
  localparam int COEFF_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COEFF  = 2'd2;

  localparam int RST_IMAGE_WIDTH  = 640;
  localparam int RST_IMAGE_HEIGHT = 480;
  localparam logic [COEFF_W-1:0] RST_RANGE_COEFF = 17'd6848;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int RANGE_ENTRIES = 4096;
  localparam int E_W   = 12;
  localparam int RNG_W = 16;
  localparam int WT_W  = 13;

  typedef logic [RNG_W-1:0] rng_tbl_t [RANGE_ENTRIES];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_TAPS,
    ST_FLUSH,
    ST_DIV,
    ST_DONE
  } brf_state_t;

  // Taylor terms of exp(-1/256) in Q0.60
  localparam logic [63:0] Q60_ONE = 64'd1 << 60;
  localparam logic [63:0] T1  = Q60_ONE / 64'd256;
  localparam logic [63:0] T2  = T1 / 64'd512;
  localparam logic [63:0] T3  = T2 / 64'd768;
  localparam logic [63:0] T4  = T3 / 64'd1024;
  localparam logic [63:0] T5  = T4 / 64'd1280;
  localparam logic [63:0] T6  = T5 / 64'd1536;
  localparam logic [63:0] T7  = T6 / 64'd1792;
  localparam logic [63:0] T8  = T7 / 64'd2048;
  localparam logic [63:0] T9  = T8 / 64'd2304;
  localparam logic [63:0] T10 = T9 / 64'd2560;
  localparam logic [63:0] T11 = T10 / 64'd2816;
  localparam logic [63:0] T12 = T11 / 64'd3072;
  localparam logic [63:0] RATIO = Q60_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
                                  - T9 + T10 - T11 + T12;

  // Range weight ROM contents: repeated products of the ratio, rounded to Q0.16
  function automatic rng_tbl_t build_range_tbl();
    rng_tbl_t      tbl;
    logic [63:0]   v;
    logic [63:0]   x;
    logic [127:0]  prod;
    v = Q60_ONE;
    for (int e = 0; e < RANGE_ENTRIES; e++) begin
      x = (v + (64'd1 << 43)) >> 44;
      if (x > 64'd65535) begin
        x = 64'd65535;
      end
      tbl[e] = x[RNG_W-1:0];
      prod = 128'(v) * 128'(RATIO);
      v = prod[123:60];
    end
    return tbl;
  endfunction

  // Gaussian spatial weight in Q0.16 by window position
  function automatic logic [WT_W-1:0] spatial_wt(input logic [2:0] ky, input logic [2:0] kx);
    logic [1:0] ay;
    logic [1:0] ax;
    logic [WT_W-1:0] w;
    ay = (ky > 3'd2) ? 2'(ky - 3'd2) : 2'(3'd2 - ky);
    ax = (kx > 3'd2) ? 2'(kx - 3'd2) : 2'(3'd2 - kx);
    unique case ({ay, ax})
      4'b0000: w = 13'd4142;
      4'b0001, 4'b0100: w = 13'd3657;
      4'b0101: w = 13'd3224;
      4'b0010, 4'b1000: w = 13'd2510;
      4'b0110, 4'b1001: w = 13'd2215;
      4'b1010: w = 13'd1520;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[design/bilateral_rgb_5x5_filter.sv]
// Top level of the 5x5 bilateral RGB filter with line history and shared tap datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in_     | request   | in_valid / in_stall   | in_cmd, in_red, in_green, in_blue
//  out_    | result    | out_valid / out_stall | out_red, out_green, out_blue,
//          |           |                       | out_row_end, out_frame_end
//  cfg_    | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request that produces no pixel leaves the block ready for the next request. A request that
// produces a pixel passes through accept, centre read, 25 tap reads through the shared tap
// pipeline (one history read per cycle), draining that pipeline, 8 restoring divide steps
// and a result load. in_stall is high from acceptance until the result sits in the output
// register. A stalled output only extends the result load. Reset is synchronous, active
// low; the history memory needs no clearing since only pixels already received are read.
`default_nettype none
`include "bilateral_rgb_5x5_filter_assert.svh"
module bilateral_rgb_5x5_filter #(
  parameter int MAX_WIDTH  = brf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = brf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brf_pkg::COEFF_W-1:0]   cfg_data
);

  localparam int HIST_DEPTH = 4 * MAX_WIDTH + 8;
  localparam int AW  = $clog2(HIST_DEPTH);
  localparam int SAW = AW + 2;
  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(2 * MAX_WIDTH + 4);
  localparam int CDW = brf_pkg::CFG_DIM_W;
  localparam int EWW = (DW > CDW) ? DW : CDW;
  localparam int EWH = (HW > CDW) ? HW : CDW;
  localparam int SUM_W = 25;
  localparam int SW_W  = 17;
  localparam int FW_RST = (brf_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                          MAX_WIDTH : brf_pkg::RST_IMAGE_WIDTH;
  localparam int FH_RST = (brf_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                          MAX_HEIGHT : brf_pkg::RST_IMAGE_HEIGHT;
  localparam logic signed [SAW-1:0] DEPTH_S = SAW'(HIST_DEPTH);
  localparam brf_pkg::rng_tbl_t RNG_TBL = brf_pkg::build_range_tbl();

  // configuration registers
  logic [CDW-1:0]              cfg_w_r, cfg_h_r;
  logic [brf_pkg::COEFF_W-1:0] coeff_r;

  // frame geometry and raster counters
  logic [DW-1:0] fw_r, fw_nxt;
  logic [HW-1:0] fh_r, fh_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [AW-1:0] in_addr_r, in_addr_nxt, out_addr_r, out_addr_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  // job being filtered
  logic [CW-1:0] job_col_r;
  logic [HW-1:0] job_row_r;
  logic [AW-1:0] job_addr_r;
  logic          job_row_end_r, job_frame_end_r;

  brf_pkg::brf_state_t state_r, state_nxt;
  logic [2:0] ky_r, ky_nxt, kx_r, kx_nxt;

  logic [23:0] mem [HIST_DEPTH];

  // tap pipeline
  logic          rd_v_r, rd_cen_r;
  logic [2:0]    rd_ky_r, rd_kx_r;
  logic [23:0]   rd_data_r;
  logic [23:0]   cen_r;
  logic          s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [23:0]   s1_pix_r, s2_pix_r, s3_pix_r, s4_pix_r;
  logic [2:0]    s1_ky_r, s1_kx_r, s2_ky_r, s2_kx_r, s3_ky_r, s3_kx_r;
  logic [17:0]   s1_d2_r;
  logic [brf_pkg::E_W-1:0]   s2_e_r;
  logic [brf_pkg::RNG_W-1:0] s3_rng_r;
  logic [brf_pkg::WT_W-1:0]  s4_wt_r;

  // sums and divider lanes
  logic [SUM_W-1:0] acc_r [3];
  logic [SW_W-1:0]  acc_w_r;
  logic [SUM_W-1:0] rem_r [3];
  logic [SUM_W-1:0] den_r;
  logic [7:0]       q_r [3];
  logic [2:0]       div_cnt_r;

  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_row_end_r, out_frame_end_r;

  // decode
  logic          accept, first_px, emit, mem_we;
  logic          col_last, last_ocol, last_orow;
  logic [DW-1:0] w_clamp, eff_w;
  logic [HW-1:0] h_clamp, eff_h;
  logic [PW-1:0] pend_inc, pend_lim;
  logic [EWW-1:0] w_ext;
  logic [EWH-1:0] h_ext;

  // sequencer controls
  logic       rd_en, rd_cen, div_init, div_step, out_load;
  logic [2:0] ky_sel, kx_sel;

  // address generation
  logic signed [HW+1:0]  ny, dy;
  logic signed [DW+1:0]  nx, dx;
  logic signed [SAW-1:0] off_y, addr_s, fw_s;
  logic [AW-1:0]         rd_addr;

  // datapath combinational values
  logic signed [17:0] dr, dg, db;
  logic [34:0]        e_prod;
  logic [28:0]        wt_prod;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != brf_pkg::ST_IDLE);

  // clamp programmed geometry: zero acts as one, saturate at the maximum
  always_comb begin
    w_ext = EWW'(cfg_w_r);
    h_ext = EWH'(cfg_h_r);
    if (w_ext == '0) begin
      w_clamp = DW'(1);
    end else if (w_ext > EWW'(MAX_WIDTH)) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = DW'(w_ext);
    end
    if (h_ext == '0) begin
      h_clamp = HW'(1);
    end else if (h_ext > EWH'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(h_ext);
    end
  end

  // request decode: store the pixel, move the raster counters, decide on emission
  always_comb begin
    first_px     = (in_row_r == '0) && (in_col_r == '0);
    eff_w        = first_px ? w_clamp : fw_r;
    eff_h        = first_px ? h_clamp : fh_r;
    fw_nxt       = fw_r;
    fh_nxt       = fh_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_addr_nxt  = in_addr_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_addr_nxt = out_addr_r;
    pend_inc     = pend_r;
    pend_nxt     = pend_r;
    pend_lim     = (PW'(eff_w) << 1) + PW'(3);
    mem_we       = 1'b0;
    emit         = 1'b0;
    col_last     = (DW'(in_col_r) == eff_w - 1'b1);
    last_ocol    = (DW'(out_col_r) == eff_w - 1'b1);
    last_orow    = (out_row_r == eff_h - 1'b1);
    if (accept) begin
      if (in_cmd == brf_pkg::CMD_PIXEL) begin
        if (first_px) begin
          fw_nxt = w_clamp;
          fh_nxt = h_clamp;
        end
        if (in_row_r < eff_h) begin
          mem_we      = 1'b1;
          in_addr_nxt = (in_addr_r == AW'(HIST_DEPTH - 1)) ? '0 : in_addr_r + 1'b1;
          in_col_nxt  = col_last ? '0 : in_col_r + 1'b1;
          in_row_nxt  = col_last ? in_row_r + 1'b1 : in_row_r;
          pend_inc    = pend_r + 1'b1;
          pend_nxt    = pend_inc;
          emit        = (pend_inc >= pend_lim);
        end
      end else begin
        emit = (in_row_r >= fh_r) && (pend_r != '0);
      end
    end
    if (emit) begin
      pend_nxt     = pend_inc - 1'b1;
      out_col_nxt  = last_ocol ? '0 : out_col_r + 1'b1;
      out_row_nxt  = last_ocol ? out_row_r + 1'b1 : out_row_r;
      out_addr_nxt = (out_addr_r == AW'(HIST_DEPTH - 1)) ? '0 : out_addr_r + 1'b1;
      if (last_ocol && last_orow) begin
        // frame finished: restart every counter
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        in_addr_nxt  = '0;
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_addr_nxt = '0;
        pend_nxt     = '0;
      end
    end
  end

  // sequencer: centre read, 25 tap reads, pipeline drain, divide, result
  always_comb begin
    state_nxt = state_r;
    ky_nxt    = ky_r;
    kx_nxt    = kx_r;
    rd_en     = 1'b0;
    rd_cen    = 1'b0;
    div_init  = 1'b0;
    div_step  = 1'b0;
    out_load  = 1'b0;
    ky_sel    = ky_r;
    kx_sel    = kx_r;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        if (emit) begin
          state_nxt = brf_pkg::ST_CENTRE;
        end
      end
      brf_pkg::ST_CENTRE: begin
        rd_cen    = 1'b1;
        ky_sel    = 3'd2;
        kx_sel    = 3'd2;
        ky_nxt    = '0;
        kx_nxt    = '0;
        state_nxt = brf_pkg::ST_TAPS;
      end
      brf_pkg::ST_TAPS: begin
        rd_en = 1'b1;
        if (kx_r == 3'd4) begin
          kx_nxt = '0;
          ky_nxt = ky_r + 1'b1;
          if (ky_r == 3'd4) begin
            state_nxt = brf_pkg::ST_FLUSH;
          end
        end else begin
          kx_nxt = kx_r + 1'b1;
        end
      end
      brf_pkg::ST_FLUSH: begin
        if (!(rd_v_r || s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
          div_init  = 1'b1;
          state_nxt = brf_pkg::ST_DIV;
        end
      end
      brf_pkg::ST_DIV: begin
        div_step = 1'b1;
        if (div_cnt_r == 3'd7) begin
          state_nxt = brf_pkg::ST_DONE;
        end
      end
      brf_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = brf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brf_pkg::ST_IDLE;
      end
    endcase
  end

  // history address of a tap: clamp to the frame, offset from the centre, wrap once
  always_comb begin
    ny = $signed({2'b00, job_row_r}) + $signed((HW+2)'(ky_sel)) - $signed((HW+2)'(2));
    if (ny < 0) begin
      ny = '0;
    end else if (ny > $signed({2'b00, fh_r - 1'b1})) begin
      ny = $signed({2'b00, fh_r - 1'b1});
    end
    dy = ny - $signed({2'b00, job_row_r});
    nx = $signed((DW+2)'(job_col_r)) + $signed((DW+2)'(kx_sel)) - $signed((DW+2)'(2));
    if (nx < 0) begin
      nx = '0;
    end else if (nx > $signed({2'b00, fw_r - 1'b1})) begin
      nx = $signed({2'b00, fw_r - 1'b1});
    end
    dx   = nx - $signed((DW+2)'(job_col_r));
    fw_s = $signed(SAW'(fw_r));
    unique case (dy[2:0])
      3'b001:  off_y = fw_s;
      3'b010:  off_y = fw_s <<< 1;
      3'b111:  off_y = -fw_s;
      3'b110:  off_y = -(fw_s <<< 1);
      default: off_y = '0;
    endcase
    addr_s = $signed({2'b00, job_addr_r}) + off_y + SAW'(dx);
    if (addr_s < 0) begin
      addr_s = addr_s + DEPTH_S;
    end else if (addr_s >= DEPTH_S) begin
      addr_s = addr_s - DEPTH_S;
    end
    rd_addr = addr_s[AW-1:0];
  end

  // tap arithmetic between pipeline registers
  always_comb begin
    dr = 18'($signed({1'b0, rd_data_r[23:16]}) - $signed({1'b0, cen_r[23:16]}));
    dg = 18'($signed({1'b0, rd_data_r[15:8]})  - $signed({1'b0, cen_r[15:8]}));
    db = 18'($signed({1'b0, rd_data_r[7:0]})   - $signed({1'b0, cen_r[7:0]}));
    e_prod  = 35'(s1_d2_r) * 35'(coeff_r);
    wt_prod = 29'(brf_pkg::spatial_wt(s3_ky_r, s3_kx_r)) * 29'(s3_rng_r);
  end

  // history memory and range ROM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_addr_r] <= {in_red, in_green, in_blue};
    end
    rd_data_r <= mem[rd_addr];
    s3_rng_r  <= RNG_TBL[s2_e_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      job_col_r       <= out_col_r;
      job_row_r       <= out_row_r;
      job_addr_r      <= out_addr_r;
      job_row_end_r   <= last_ocol;
      job_frame_end_r <= last_ocol && last_orow;
    end
    rd_ky_r <= ky_r;
    rd_kx_r <= kx_r;
    if (rd_cen_r) begin
      cen_r <= rd_data_r;
    end
    s1_pix_r <= rd_data_r;
    s1_ky_r  <= rd_ky_r;
    s1_kx_r  <= rd_kx_r;
    s1_d2_r  <= 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
    s2_pix_r <= s1_pix_r;
    s2_ky_r  <= s1_ky_r;
    s2_kx_r  <= s1_kx_r;
    s2_e_r   <= (e_prod[34:16] > 19'd4095) ? 12'd4095 : e_prod[27:16];
    s3_pix_r <= s2_pix_r;
    s3_ky_r  <= s2_ky_r;
    s3_kx_r  <= s2_kx_r;
    s4_pix_r <= s3_pix_r;
    s4_wt_r  <= wt_prod[28:16];
    if (emit) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
      end
      acc_w_r <= '0;
    end else if (s4_v_r) begin
      acc_r[0] <= acc_r[0] + SUM_W'(s4_wt_r * s4_pix_r[23:16]);
      acc_r[1] <= acc_r[1] + SUM_W'(s4_wt_r * s4_pix_r[15:8]);
      acc_r[2] <= acc_r[2] + SUM_W'(s4_wt_r * s4_pix_r[7:0]);
      acc_w_r  <= acc_w_r + SW_W'(s4_wt_r);
    end
    if (div_init) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= acc_r[c];
        q_r[c]   <= '0;
      end
      den_r <= {1'b0, acc_w_r, 7'b0};
    end else if (div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= den_r) begin
          rem_r[c] <= rem_r[c] - den_r;
          q_r[c]   <= {q_r[c][6:0], 1'b1};
        end else begin
          q_r[c]   <= {q_r[c][6:0], 1'b0};
        end
      end
      den_r <= den_r >> 1;
    end
    if (out_load) begin
      out_red_r       <= q_r[0];
      out_green_r     <= q_r[1];
      out_blue_r      <= q_r[2];
      out_row_end_r   <= job_row_end_r;
      out_frame_end_r <= job_frame_end_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= CDW'(brf_pkg::RST_IMAGE_WIDTH);
      cfg_h_r     <= CDW'(brf_pkg::RST_IMAGE_HEIGHT);
      coeff_r     <= brf_pkg::RST_RANGE_COEFF;
      fw_r        <= DW'(FW_RST);
      fh_r        <= HW'(FH_RST);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_addr_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_addr_r  <= '0;
      pend_r      <= '0;
      state_r     <= brf_pkg::ST_IDLE;
      ky_r        <= '0;
      kx_r        <= '0;
      rd_v_r      <= 1'b0;
      rd_cen_r    <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          brf_pkg::CFG_IMAGE_WIDTH:  cfg_w_r <= cfg_data[CDW-1:0];
          brf_pkg::CFG_IMAGE_HEIGHT: cfg_h_r <= cfg_data[CDW-1:0];
          brf_pkg::CFG_RANGE_COEFF:  coeff_r <= cfg_data;
          default: ;
        endcase
      end
      fw_r       <= fw_nxt;
      fh_r       <= fh_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_addr_r  <= in_addr_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_addr_r <= out_addr_nxt;
      pend_r     <= pend_nxt;
      state_r    <= state_nxt;
      ky_r       <= ky_nxt;
      kx_r       <= kx_nxt;
      rd_v_r     <= rd_en;
      rd_cen_r   <= rd_cen;
      s1_v_r     <= rd_v_r;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      s4_v_r     <= s3_v_r;
      div_cnt_r  <= div_init ? '0 : (div_step ? div_cnt_r + 1'b1 : div_cnt_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  `BRF_ASSERT_IMPL(a_pend_bound, 1'b1, pend_r <= (PW'(fw_r) << 1) + PW'(3))
  `BRF_ASSERT_IMPL(a_col_range, 1'b1, DW'(in_col_r) < fw_r)
  `BRF_ASSERT_IMPL(a_div_nonzero, state_r == brf_pkg::ST_DIV, acc_w_r != '0)
  `BRF_ASSERT_IMPL(a_pipe_empty, state_r == brf_pkg::ST_DIV, !(s4_v_r || rd_v_r))
  `BRF_ASSERT_IMPL(a_frame_row, out_valid_r && out_frame_end_r, out_row_end_r)
  `BRF_ASSERT_NEXT(a_centre_taps, state_r == brf_pkg::ST_CENTRE, state_r == brf_pkg::ST_TAPS)

endmodule
`default_nettype wire

[tb/sv/tb_bilateral_rgb_5x5_filter.sv]
// Self-checking testbench for the 5x5 bilateral RGB filter.
`timescale 1ns / 100ps
`default_nettype none
module tb_bilateral_rgb_5x5_filter;

  localparam int STORE_DEPTH = 4 * brf_pkg::MAX_WIDTH_DEF + 8;
  localparam int IDLE_PCT    = 11;
  localparam int SETTLE_CYC  = 60;

  typedef struct {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } request_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = brf_pkg::CMD_PIXEL;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic out_row_end, out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [brf_pkg::CFG_IDX_W-1:0] cfg_index = brf_pkg::CFG_IMAGE_WIDTH;
  logic [brf_pkg::COEFF_W-1:0] cfg_data = '0;

  bilateral_rgb_5x5_filter dut (.*);

  // Testbench state
  request_t pending_requests[$];
  pixel_t   filtered_pixels[$];
  int errors = 0;
  int requests_sent = 0;
  int pixels_checked = 0;
  int frames_run = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;
  bit quiet = 1'b0;
  bit offer_taken = 1'b0;

  // Predictor state: registers, latched geometry, counters and pixel history
  int unsigned reg_width, reg_height, reg_coeff;
  int unsigned frame_w, frame_h;
  int unsigned in_col, in_row, out_col, out_row;
  logic [23:0] pixel_history [STORE_DEPTH];
  logic [15:0] range_weight [brf_pkg::RANGE_ENTRIES];
  int unsigned gauss [25] = '{
    1520, 2215, 2510, 2215, 1520,
    2215, 3224, 3657, 3224, 2215,
    2510, 3657, 4142, 3657, 2510,
    2215, 3224, 3657, 3224, 2215,
    1520, 2215, 2510, 2215, 1520};

  initial forever #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // exp(-e/256) table in Q0.16, from repeated Q0.60 products of exp(-1/256)
  function automatic void build_range_weights();
    logic [63:0] term, ratio, v, x;
    logic [127:0] prod;
    term = 64'd1 << 60;
    ratio = term;
    v = term;
    for (int n = 1; n <= 12; n++) begin
      term = term / (64'd256 * 64'(n));
      if (n % 2 == 1) begin
        ratio = ratio - term;
      end else begin
        ratio = ratio + term;
      end
    end
    for (int e = 0; e < brf_pkg::RANGE_ENTRIES; e++) begin
      x = (v + (64'd1 << 43)) >> 44;
      if (x > 64'd65535) x = 64'd65535;
      range_weight[e] = x[15:0];
      prod = 128'(v) * 128'(ratio);
      v = prod[123:60];
    end
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Filter the pixel at the output position and advance the output counters
  function automatic void filter_next_pixel();
    int ny, nx;
    logic [23:0] taps [25];
    int unsigned sr, sg, sb, sw, wt, d2;
    int dr, dg, db;
    logic [63:0] e;
    pixel_t px;
    for (int ky = -2; ky <= 2; ky++) begin
      ny = int'(out_row) + ky;
      if (ny < 0) ny = 0;
      if (ny > int'(frame_h) - 1) ny = int'(frame_h) - 1;
      for (int kx = -2; kx <= 2; kx++) begin
        nx = int'(out_col) + kx;
        if (nx < 0) nx = 0;
        if (nx > int'(frame_w) - 1) nx = int'(frame_w) - 1;
        taps[(ky + 2) * 5 + kx + 2] =
          pixel_history[(ny * int'(frame_w) + nx) % STORE_DEPTH];
      end
    end
    sr = 0; sg = 0; sb = 0; sw = 0;
    for (int i = 0; i < 25; i++) begin
      dr = int'(taps[i][23:16]) - int'(taps[12][23:16]);
      dg = int'(taps[i][15:8]) - int'(taps[12][15:8]);
      db = int'(taps[i][7:0]) - int'(taps[12][7:0]);
      d2 = dr * dr + dg * dg + db * db;
      e = (64'(d2) * 64'(reg_coeff)) >> 16;
      if (e > brf_pkg::RANGE_ENTRIES - 1) e = brf_pkg::RANGE_ENTRIES - 1;
      wt = (gauss[i] * range_weight[e]) >> 16;
      sr += wt * taps[i][23:16];
      sg += wt * taps[i][15:8];
      sb += wt * taps[i][7:0];
      sw += wt;
    end
    sr /= sw; sg /= sw; sb /= sw;
    px.red       = (sr > 255) ? 8'd255 : sr[7:0];
    px.green     = (sg > 255) ? 8'd255 : sg[7:0];
    px.blue      = (sb > 255) ? 8'd255 : sb[7:0];
    px.row_end   = (out_col == frame_w - 1);
    px.frame_end = (out_col == frame_w - 1) && (out_row == frame_h - 1);
    filtered_pixels.push_back(px);
    out_col++;
    if (out_col >= frame_w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= frame_h) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
  endfunction

  // Advance the predictor by one accepted request
  function automatic void predict_request(request_t rq);
    int unsigned n_in, n_out;
    if (rq.cmd == brf_pkg::CMD_PIXEL) begin
      if (in_row == 0 && in_col == 0) begin
        frame_w = clamp_dim(reg_width, brf_pkg::MAX_WIDTH_DEF);
        frame_h = clamp_dim(reg_height, brf_pkg::MAX_HEIGHT_DEF);
      end
      if (in_row >= frame_h) return;
      n_in = in_row * frame_w + in_col;
      pixel_history[n_in % STORE_DEPTH] = {rq.red, rq.green, rq.blue};
      n_in++;
      in_col++;
      if (in_col >= frame_w) begin
        in_col = 0;
        in_row++;
      end
      n_out = out_row * frame_w + out_col;
      if (n_in - n_out >= 2 * frame_w + 3) filter_next_pixel();
    end else begin
      if (in_row < frame_h) return;
      n_out = out_row * frame_w + out_col;
      if (n_out < frame_w * frame_h) filter_next_pixel();
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at pixel %0d: %s got %0d want %0d", pixels_checked, what, got, want);
    errors++;
  endtask

  // Request driver: take the head of the pending queue on acceptance, present at falling edge
  always @(posedge clk) begin
    request_t rq;
    if (rst_n && in_valid && !in_stall) begin
      rq = pending_requests.pop_front();
      predict_request(rq);
      requests_sent++;
      offer_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      // hold the payload until it is taken; then present the next request or idle
      if (!in_valid || offer_taken) begin
        offer_taken = 1'b0;
        if (pending_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_cmd   <= pending_requests[0].cmd;
          in_red   <= pending_requests[0].red;
          in_green <= pending_requests[0].green;
          in_blue  <= pending_requests[0].blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Result monitor: compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_pixels.size() == 0) begin
        $display("unexpected output pixel after %0d checked", pixels_checked);
        errors++;
      end else begin
        want = filtered_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_row_end !== want.row_end)
          report_mismatch("row_end", out_row_end, want.row_end);
        if (out_frame_end !== want.frame_end)
          report_mismatch("frame_end", out_frame_end, want.frame_end);
      end
      pixels_checked++;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the input backs up
  initial begin
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (800) @(posedge clk);
    hold_off = 1'b0;
  end

  // A stretch with no idling on either side
  always @(posedge clk) quiet <= (cycle_count >= 9000 && cycle_count < 15000);

  // Watchdog
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_register(logic [brf_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[brf_pkg::COEFF_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      brf_pkg::CFG_IMAGE_WIDTH:  reg_width  = value & 32'h7FF;
      brf_pkg::CFG_IMAGE_HEIGHT: reg_height = value & 32'h7FF;
      brf_pkg::CFG_RANGE_COEFF:  reg_coeff  = value & 32'h1FFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every pixel has come out, then let the block settle
  task automatic wait_drained();
    while (pending_requests.size() != 0 || filtered_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic void push_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    request_t rq;
    rq.cmd = cmd; rq.red = r; rq.green = g; rq.blue = b;
    pending_requests.push_back(rq);
  endfunction

  // Pixel content: mostly noisy flat patches, some fully random, some at the extremes
  function automatic logic [7:0] sample(int kind, logic [7:0] base);
    int v;
    case (kind)
      0: return 8'($urandom);
      1: begin
        v = int'(base) + $urandom_range(0, 16) - 8;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
      end
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Program geometry and strength, then send one full frame with noise and drain ticks
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned coeff, bit noisy);
    int unsigned ew, eh, pend;
    int kind;
    logic [7:0] br, bg, bb;
    write_register(brf_pkg::CFG_IMAGE_WIDTH, w);
    write_register(brf_pkg::CFG_IMAGE_HEIGHT, h);
    write_register(brf_pkg::CFG_RANGE_COEFF, coeff);
    ew = clamp_dim(w & 32'h7FF, brf_pkg::MAX_WIDTH_DEF);
    eh = clamp_dim(h & 32'h7FF, brf_pkg::MAX_HEIGHT_DEF);
    pend = (ew * eh < 2 * ew + 2) ? ew * eh : 2 * ew + 2;
    kind = $urandom_range(0, 9);
    kind = (kind < 4) ? 0 : (kind < 9) ? 1 : 2;
    br = $urandom; bg = $urandom; bb = $urandom;
    // drain before the frame is complete: ignored
    push_request(brf_pkg::CMD_DRAIN, $urandom, $urandom, $urandom);
    for (int i = 0; i < ew * eh; i++) begin
      if (kind == 1 && $urandom_range(0, 15) == 0) begin
        br = $urandom; bg = $urandom; bb = $urandom;
      end
      push_request(brf_pkg::CMD_PIXEL, sample(kind, br), sample(kind, bg), sample(kind, bb));
      if (noisy && $urandom_range(0, 19) == 0)
        push_request(brf_pkg::CMD_DRAIN, $urandom, $urandom, $urandom);
    end
    for (int i = 0; i < pend; i++) begin
      // pixel while the tail is still pending: ignored
      if (noisy && $urandom_range(0, 9) == 0)
        push_request(brf_pkg::CMD_PIXEL, $urandom, $urandom, $urandom);
      push_request(brf_pkg::CMD_DRAIN, $urandom, $urandom, $urandom);
    end
    // drain with nothing pending: ignored
    push_request(brf_pkg::CMD_DRAIN, $urandom, $urandom, $urandom);
    frames_run++;
    wait_drained();
  endtask

  initial begin
    int unsigned w, h, c;
    build_range_weights();
    reg_width = brf_pkg::RST_IMAGE_WIDTH;
    reg_height = brf_pkg::RST_IMAGE_HEIGHT;
    reg_coeff = brf_pkg::RST_RANGE_COEFF;
    frame_w = reg_width; frame_h = reg_height;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    foreach (pixel_history[i]) pixel_history[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: a 3x3 frame of extremes with zero strength and an early drain
    write_register(brf_pkg::CFG_IMAGE_WIDTH, 3);
    write_register(brf_pkg::CFG_IMAGE_HEIGHT, 3);
    write_register(brf_pkg::CFG_RANGE_COEFF, 0);
    push_request(brf_pkg::CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 9; i++) begin
      if (i % 2 == 0) push_request(brf_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
      else            push_request(brf_pkg::CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    end
    push_request(brf_pkg::CMD_PIXEL, 8'hAA, 8'h55, 8'hAA);
    for (int i = 0; i < 8; i++) push_request(brf_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    push_request(brf_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
    frames_run++;
    wait_drained();
    // zero geometry acts as one, strongest and weakest range sigma
    run_frame(0, 0, 131071, 1'b0);
    run_frame(1, 4, 1, 1'b1);
    run_frame(6, 1, 131071, 1'b1);

    // Random frames: mostly small geometries and varied strengths
    while (requests_sent < 650) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0: c = $urandom_range(0, 131071);
        1: c = $urandom_range(1, 200);
        2: c = 131071;
        3: c = brf_pkg::RST_RANGE_COEFF;
        default: c = $urandom_range(200, 20000);
      endcase
      run_frame(w, h, c, 1'b1);
    end

    // Extreme geometry: saturated height on a single column
    run_frame(1, 2047, 2000, 1'b0);

    $display("covered %0d frames, %0d requests and %0d filtered pixels,",
             frames_run, requests_sent, pixels_checked);
    $display("with zero, saturated and single-pixel geometries and the full strength range");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[bilateral_rgb_5x5_filter.f]
+incdir+design
design/brf_pkg.sv
design/bilateral_rgb_5x5_filter.sv
tb/sv/tb_bilateral_rgb_5x5_filter.sv
